/* hw/rtl/msnt_pkg.sv */
// ----------------------------------------------------------------------------
// msnt_pkg
// Shared types, codes and sizes of the sustain pedal note tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package msnt_pkg;

	localparam int KEY_COUNT   = 128;
	localparam int GROUP_BITS  = 64;
	localparam int KEY_BITS    = 2 * GROUP_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MIN_LENGTH = 2'd3;

	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_CONTROL  = 4'hB;

	localparam logic [1:0] CFG_SUSTAIN_THRESHOLD  = 2'd0;
	localparam logic [1:0] CFG_SUSTAIN_CONTROLLER = 2'd1;
	localparam logic [1:0] CFG_REVERB_CONTROLLER  = 2'd2;

	localparam logic [6:0] RST_SUSTAIN_THRESHOLD  = 7'd64;
	localparam logic [6:0] RST_SUSTAIN_CONTROLLER = 7'd64;
	localparam logic [6:0] RST_REVERB_CONTROLLER  = 7'd91;

	typedef enum logic [2:0] {
		ACT_NOTE_ON  = 3'd0,
		ACT_NOTE_OFF = 3'd1,
		ACT_REVERB   = 3'd2,
		ACT_CC       = 3'd3,
		ACT_RELEASE  = 3'd4
	} action_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [1:0] message_length;
	} item_t;

	typedef struct packed {
		logic [6:0] sustain_threshold;
		logic [6:0] sustain_controller;
		logic [6:0] reverb_controller;
	} cfg_t;

	typedef struct packed {
		action_t                 action;
		logic [6:0]              key_or_controller;
		logic [6:0]              level;
		logic                    group_upper;
		logic [GROUP_BITS-1:0]   release_mask;
		logic                    last_result;
	} result_t;

	typedef struct packed {
		logic    push_a;
		logic    push_b;
		result_t res_a;
		result_t res_b;
	} emit_t;

endpackage

`default_nettype wire

/* hw/rtl/midi_sustain_note_tracker.sv */
// path: a request passes through the input register and then the result queue
// throughput: one request per cycle while the queue has room; a pedal release
//   gives two results, and the output paces them at one per cycle unless stalled
// reset: asynchronous, clears pedal flag, both key sets and the result queue;
//   configuration registers return to 64 / 64 / 91
// ----------------------------------------------------------------------------
// midi_sustain_note_tracker
// One-channel MIDI message decoder with sustain pedal key tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_sustain_note_tracker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [1:0]                        cfg_index,
	input  wire  [6:0]                        cfg_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [7:0]                        status_byte,
	input  wire  [7:0]                        first_data,
	input  wire  [7:0]                        second_data,
	input  wire  [1:0]                        message_length,
	output logic                              out_valid,
	input  wire                               out_stall,
	output msnt_pkg::action_t                 action,
	output logic [6:0]                        key_or_controller,
	output logic [6:0]                        level,
	output logic                              group_upper,
	output logic [msnt_pkg::GROUP_BITS-1:0]   release_mask,
	output logic                              last_result
);
	import msnt_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    room;
	logic    commit;
	logic    accept;
	emit_t   emit;
	result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sustain_threshold  <= RST_SUSTAIN_THRESHOLD;
			cfg_q.sustain_controller <= RST_SUSTAIN_CONTROLLER;
			cfg_q.reverb_controller  <= RST_REVERB_CONTROLLER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SUSTAIN_THRESHOLD:  cfg_q.sustain_threshold  <= cfg_data;
				CFG_SUSTAIN_CONTROLLER: cfg_q.sustain_controller <= cfg_data;
				CFG_REVERB_CONTROLLER:  cfg_q.reverb_controller  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		commit   = valid_s1 && room;
		in_stall = valid_s1 && !room;
		accept   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.status_byte    <= status_byte;
			item_s1.first_data     <= first_data;
			item_s1.second_data    <= second_data;
			item_s1.message_length <= message_length;
		end
	end

	msnt_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.cfg    (cfg_q),
		.emit   (emit)
	);

	msnt_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	always_comb begin
		action            = head.action;
		key_or_controller = head.key_or_controller;
		level             = head.level;
		group_upper       = head.group_upper;
		release_mask      = head.release_mask;
		last_result       = head.last_result;
	end

endmodule

`default_nettype wire

/* hw/rtl/msnt_tracker.sv */
// ----------------------------------------------------------------------------
// msnt_tracker
// Message decode, sustain flag and held / sustained key sets.
// ----------------------------------------------------------------------------
`default_nettype none

module msnt_tracker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 commit,
	input  wire msnt_pkg::item_t item,
	input  wire msnt_pkg::cfg_t  cfg,
	output msnt_pkg::emit_t     emit
);
	import msnt_pkg::*;

	logic                sustain_q;
	logic [KEY_BITS-1:0] held_q;
	logic [KEY_BITS-1:0] sustained_q;

	logic                sustain_d;
	logic [KEY_BITS-1:0] held_d;
	logic [KEY_BITS-1:0] sustained_d;
	logic [KEY_BITS-1:0] key_bit;
	logic [KEY_BITS-1:0] pending;
	logic [3:0]          cmd;
	logic [6:0]          d1;
	logic [6:0]          d2;
	logic                in_range;
	result_t             res_a;
	result_t             res_b;
	logic                push_a;
	logic                push_b;

	always_comb begin
		cmd       = item.status_byte[7:4];
		d1        = item.first_data[6:0];
		d2        = item.second_data[6:0];
		in_range  = {1'b0, d1} < 8'(KEY_COUNT);
		key_bit   = KEY_BITS'(1) << d1;
		pending   = sustained_q & ~held_q;
		sustain_d   = sustain_q;
		held_d      = held_q;
		sustained_d = sustained_q;
		push_a    = 1'b0;
		push_b    = 1'b0;
		res_a     = '0;
		res_b     = '0;
		res_a.last_result = 1'b1;

		if (item.message_length == MIN_LENGTH) begin
			case (cmd)
				CMD_NOTE_OFF: begin
					if (!sustain_q) begin
						push_a = 1'b1;
						res_a.action = ACT_NOTE_OFF;
						res_a.key_or_controller = d1;
						if (in_range)
							sustained_d = sustained_q & ~key_bit;
					end
					if (in_range)
						held_d = held_q & ~key_bit;
				end
				CMD_NOTE_ON: begin
					if (in_range) begin
						held_d = held_q | key_bit;
						if (sustain_q)
							sustained_d = sustained_q | key_bit;
					end
					push_a = 1'b1;
					res_a.action = ACT_NOTE_ON;
					res_a.key_or_controller = d1;
					res_a.level = d2;
				end
				CMD_CONTROL: begin
					if (d1 == cfg.sustain_controller) begin
						if (d2 >= cfg.sustain_threshold) begin
							sustain_d   = 1'b1;
							sustained_d = sustained_q | held_q;
						end else begin
							sustain_d   = 1'b0;
							sustained_d = '0;
							push_a = 1'b1;
							push_b = 1'b1;
							res_a.action = ACT_RELEASE;
							res_a.release_mask = pending[GROUP_BITS-1:0];
							res_a.last_result = 1'b0;
							res_b.action = ACT_RELEASE;
							res_b.group_upper = 1'b1;
							res_b.release_mask = pending[KEY_BITS-1:GROUP_BITS];
							res_b.last_result = 1'b1;
						end
					end else begin
						push_a = 1'b1;
						res_a.action = (d1 == cfg.reverb_controller) ? ACT_REVERB : ACT_CC;
						res_a.key_or_controller = d1;
						res_a.level = d2;
					end
				end
				default: ;
			endcase
		end

		emit.push_a = push_a & commit;
		emit.push_b = push_b & commit;
		emit.res_a  = res_a;
		emit.res_b  = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q   <= 1'b0;
			held_q      <= '0;
			sustained_q <= '0;
		end else if (commit) begin
			sustain_q   <= sustain_d;
			held_q      <= held_d;
			sustained_q <= sustained_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/msnt_result_queue.sv */
// ----------------------------------------------------------------------------
// msnt_result_queue
// Small result queue taking up to two results a cycle, handing out one while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module msnt_result_queue (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire msnt_pkg::emit_t       emit,
	output logic                       room,
	output logic                       out_valid,
	input  wire                        out_stall,
	output msnt_pkg::result_t          head
);
	import msnt_pkg::*;

	result_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QCNT_W-1:0]   n_push;
	logic [QPTR_W-1:0]   wr_next;

	always_comb begin
		out_valid = count_q != '0;
		head      = entry_q[rd_ptr_q];
		pop       = out_valid && !out_stall;
		room      = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
		n_push    = QCNT_W'(emit.push_a) + QCNT_W'(emit.push_b);
		wr_next   = wr_ptr_q + QPTR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (emit.push_a)
			entry_q[wr_ptr_q] <= emit.res_a;
		if (emit.push_b)
			entry_q[wr_next] <= emit.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* tb/msnt_score_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnt_score_pkg
// Scoreboard for the sustain pedal note tracker: keeps its own pedal flag,
// held and sustained key sets and register copies, works out the events each
// accepted request should cause and checks the block's events in order.
// ----------------------------------------------------------------------------

package msnt_score_pkg;

	import msnt_pkg::*;

	class note_event_board;
		logic [6:0]          threshold;
		logic [6:0]          pedal_ctl;
		logic [6:0]          reverb_ctl;
		logic                pedal_down;
		logic [KEY_BITS-1:0] down_keys;
		logic [KEY_BITS-1:0] ringing_keys;
		result_t             due_events[$];
		int                  errors;

		function new();
			threshold    = RST_SUSTAIN_THRESHOLD;
			pedal_ctl    = RST_SUSTAIN_CONTROLLER;
			reverb_ctl   = RST_REVERB_CONTROLLER;
			pedal_down   = 1'b0;
			down_keys    = '0;
			ringing_keys = '0;
			errors       = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [6:0] val);
			case (idx)
				CFG_SUSTAIN_THRESHOLD: threshold = val;
				CFG_SUSTAIN_CONTROLLER: pedal_ctl = val;
				CFG_REVERB_CONTROLLER: reverb_ctl = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		function void add_event(action_t act, logic [6:0] key, logic [6:0] lvl, logic grp,
				logic [GROUP_BITS-1:0] mask, logic last);
			result_t ev;
			ev.action            = act;
			ev.key_or_controller = key;
			ev.level             = lvl;
			ev.group_upper       = grp;
			ev.release_mask      = mask;
			ev.last_result       = last;
			due_events.push_back(ev);
		endfunction

		function void accept_message(item_t msg);
			logic [3:0] cmd;
			logic [6:0] key;
			logic [6:0] val;
			bit         on_board;
			cmd      = msg.status_byte[7:4];
			key      = msg.first_data[6:0];
			val      = msg.second_data[6:0];
			on_board = int'(key) < KEY_COUNT;
			if (msg.message_length < MIN_LENGTH)
				return;
			case (cmd)
				CMD_NOTE_OFF: begin
					if (!pedal_down) begin
						add_event(ACT_NOTE_OFF, key, 7'd0, 1'b0, '0, 1'b1);
						if (on_board)
							ringing_keys[key] = 1'b0;
					end
					if (on_board)
						down_keys[key] = 1'b0;
				end
				CMD_NOTE_ON: begin
					if (on_board) begin
						if (pedal_down)
							ringing_keys[key] = 1'b1;
						down_keys[key] = 1'b1;
					end
					add_event(ACT_NOTE_ON, key, val, 1'b0, '0, 1'b1);
				end
				CMD_CONTROL: begin
					if (key == pedal_ctl) begin
						if (val >= threshold) begin
							pedal_down   = 1'b1;
							ringing_keys = ringing_keys | down_keys;
						end else begin
							pedal_down = 1'b0;
							add_event(ACT_RELEASE, 7'd0, 7'd0, 1'b0,
								ringing_keys[GROUP_BITS-1:0] & ~down_keys[GROUP_BITS-1:0], 1'b0);
							add_event(ACT_RELEASE, 7'd0, 7'd0, 1'b1,
								ringing_keys[KEY_BITS-1:GROUP_BITS]
								& ~down_keys[KEY_BITS-1:GROUP_BITS], 1'b1);
							ringing_keys = '0;
						end
					end else if (key == reverb_ctl) begin
						add_event(ACT_REVERB, key, val, 1'b0, '0, 1'b1);
					end else begin
						add_event(ACT_CC, key, val, 1'b0, '0, 1'b1);
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void match_event(result_t got);
			result_t want;
			if (due_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual action %0d",
					$time, got.action);
				errors++;
				return;
			end
			want = due_events.pop_front();
			compare("action", 64'(want.action), 64'(got.action));
			compare("key_or_controller", 64'(want.key_or_controller),
				64'(got.key_or_controller));
			compare("level", 64'(want.level), 64'(got.level));
			compare("group_upper", 64'(want.group_upper), 64'(got.group_upper));
			compare("release_mask", want.release_mask, got.release_mask);
			compare("last_result", 64'(want.last_result), 64'(got.last_result));
		endfunction
	endclass

endpackage

/* tb/midi_sustain_note_tracker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_sustain_note_tracker_test
// Drives MIDI messages into the sustain pedal note tracker under random
// sender bursts and receiver stalls, across several register settings, and
// checks every note, controller and release event against the scoreboard.
// ----------------------------------------------------------------------------

module midi_sustain_note_tracker_test;

	import msnt_pkg::*;
	import msnt_score_pkg::*;

	localparam logic [1:0] CFG_UNUSED           = 2'd3;
	localparam logic [3:0] CMD_DATA_BYTE        = 4'h7;
	localparam logic [3:0] CMD_POLY_PRESSURE    = 4'hA;
	localparam logic [3:0] CMD_PROGRAM          = 4'hC;
	localparam logic [3:0] CMD_CHANNEL_PRESSURE = 4'hD;
	localparam logic [3:0] CMD_PITCH_BEND       = 4'hE;
	localparam logic [3:0] CMD_SYSTEM           = 4'hF;
	localparam int         WATCHDOG_LIMIT       = 2000;
	localparam int         PHASE_REQUESTS       = 115;
	localparam int         DIRECTED_COUNT       = 26;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_we         = 1'b0;
	logic [1:0]            cfg_index      = '0;
	logic [6:0]            cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [7:0]            status_byte    = '0;
	logic [7:0]            first_data     = '0;
	logic [7:0]            second_data    = '0;
	logic [1:0]            message_length = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	action_t               action;
	logic [6:0]            key_or_controller;
	logic [6:0]            level;
	logic                  group_upper;
	logic [GROUP_BITS-1:0] release_mask;
	logic                  last_result;

	note_event_board sb;
	int              burst_left = 0;
	int              stall_mode = 0;
	int              stall_left = 0;
	int              quiet_cycles = 0;

	item_t directed_msgs [DIRECTED_COUNT] = '{
		'{{CMD_NOTE_ON, 4'h0}, 8'd0, 8'h7F, MIN_LENGTH},
		'{{CMD_NOTE_ON, 4'hF}, 8'd127, 8'd0, MIN_LENGTH},
		'{{CMD_NOTE_ON, 4'h5}, 8'hC5, 8'hFF, MIN_LENGTH},
		'{{CMD_NOTE_OFF, 4'h0}, 8'd0, 8'h7F, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, {1'b0, RST_SUSTAIN_CONTROLLER}, 8'd64, MIN_LENGTH},
		'{{CMD_NOTE_ON, 4'h0}, 8'd10, 8'd48, MIN_LENGTH},
		'{{CMD_NOTE_OFF, 4'h0}, 8'd10, 8'd0, MIN_LENGTH},
		'{{CMD_NOTE_OFF, 4'hF}, 8'd127, 8'd64, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, {1'b0, RST_SUSTAIN_CONTROLLER}, 8'd63, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, {1'b0, RST_SUSTAIN_CONTROLLER}, 8'd0, MIN_LENGTH},
		'{{CMD_NOTE_OFF, 4'h5}, 8'hC5, 8'd0, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h3}, {1'b0, RST_REVERB_CONTROLLER}, 8'd100, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, 8'd7, 8'h7F, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, 8'h87, 8'h80, MIN_LENGTH},
		'{{CMD_NOTE_ON, 4'h0}, 8'd32, 8'd32, 2'd2},
		'{{CMD_NOTE_ON, 4'h0}, 8'd32, 8'd32, 2'd1},
		'{{CMD_NOTE_ON, 4'h0}, 8'd32, 8'd32, 2'd0},
		'{{CMD_SYSTEM, 4'h0}, {1'b0, RST_SUSTAIN_CONTROLLER}, 8'd0, MIN_LENGTH},
		'{{CMD_POLY_PRESSURE, 4'h0}, 8'd1, 8'd1, MIN_LENGTH},
		'{{CMD_PROGRAM, 4'h0}, 8'd1, 8'd1, MIN_LENGTH},
		'{{CMD_CHANNEL_PRESSURE, 4'h0}, 8'd1, 8'd1, MIN_LENGTH},
		'{{CMD_PITCH_BEND, 4'h0}, 8'd1, 8'd1, MIN_LENGTH},
		'{{CMD_DATA_BYTE, 4'h0}, 8'd1, 8'd1, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, {1'b1, RST_SUSTAIN_CONTROLLER}, 8'd64, MIN_LENGTH},
		'{{CMD_NOTE_ON, 4'h0}, 8'd70, 8'd5, MIN_LENGTH},
		'{{CMD_CONTROL, 4'h0}, {1'b0, RST_SUSTAIN_CONTROLLER}, 8'd0, MIN_LENGTH}
	};

	midi_sustain_note_tracker dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.status_byte       (status_byte),
		.first_data        (first_data),
		.second_data       (second_data),
		.message_length    (message_length),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.action            (action),
		.key_or_controller (key_or_controller),
		.level             (level),
		.group_upper       (group_upper),
		.release_mask      (release_mask),
		.last_result       (last_result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_t got;
			got.action            = action;
			got.key_or_controller = key_or_controller;
			got.level             = level;
			got.group_upper       = group_upper;
			got.release_mask      = release_mask;
			got.last_result       = last_result;
			sb.match_event(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[midi_sustain_note_tracker] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t random_message();
		item_t       msg;
		int unsigned pick;
		logic [6:0]  key;
		logic [6:0]  val;
		pick = $urandom_range(0, 99);
		key  = $urandom_range(0, 1) ? 7'($urandom_range(58, 69)) : 7'($urandom);
		msg.message_length = MIN_LENGTH;
		msg.first_data     = {1'($urandom), key};
		msg.second_data    = 8'($urandom);
		if (pick < 35) begin
			msg.status_byte = {CMD_NOTE_ON, 4'($urandom)};
		end else if (pick < 60) begin
			msg.status_byte = {CMD_NOTE_OFF, 4'($urandom)};
		end else if (pick < 88) begin
			msg.status_byte = {CMD_CONTROL, 4'($urandom)};
			if (pick < 72) begin
				if ($urandom_range(0, 1) && sb.threshold != 7'd0)
					val = 7'($urandom_range(0, int'(sb.threshold) - 1));
				else
					val = 7'($urandom_range(int'(sb.threshold), 127));
				msg.first_data  = {1'($urandom), sb.pedal_ctl};
				msg.second_data = {1'($urandom), val};
			end else if (pick < 77) begin
				msg.first_data = {1'($urandom), sb.reverb_ctl};
			end
		end else begin
			// noise: any status, any length
			msg.status_byte    = 8'($urandom);
			msg.message_length = 2'($urandom);
		end
		return msg;
	endfunction

	task automatic send_message(item_t msg);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 2) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		in_valid       <= 1'b1;
		status_byte    <= msg.status_byte;
		first_data     <= msg.first_data;
		second_data    <= msg.second_data;
		message_length <= msg.message_length;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.accept_message(msg);
		burst_left--;
	endtask

	task automatic go_idle(int settle);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_config(logic [6:0] thr, logic [6:0] pedal, logic [6:0] reverb,
			bit with_unused);
		// requests with no event may still be in flight
		go_idle(4);
		cfg_write(CFG_SUSTAIN_THRESHOLD, thr);
		cfg_write(CFG_SUSTAIN_CONTROLLER, pedal);
		cfg_write(CFG_REVERB_CONTROLLER, reverb);
		if (with_unused)
			cfg_write(CFG_UNUSED, 7'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t      msg;
		int         counted;
		bit         paused;
		logic [6:0] shared_ctl;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		apply_config(RST_SUSTAIN_THRESHOLD, RST_SUSTAIN_CONTROLLER, RST_REVERB_CONTROLLER, 1'b0);
		foreach (directed_msgs[i])
			send_message(directed_msgs[i]);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: apply_config(7'd0, 7'd0, 7'd127, 1'b0);
				2: apply_config(7'd127, 7'd127, 7'd0, 1'b0);
				3: begin
					shared_ctl = 7'($urandom);
					// sustain and reverb on one controller
					apply_config(7'd1, shared_ctl, shared_ctl, 1'b0);
				end
				4: apply_config(7'($urandom_range(1, 126)), 7'($urandom), 7'($urandom), 1'b1);
				5: apply_config(RST_SUSTAIN_THRESHOLD, RST_SUSTAIN_CONTROLLER,
					RST_REVERB_CONTROLLER, 1'b1);
				default: ;
			endcase
			counted = 0;
			paused  = 1'b0;
			while (counted < PHASE_REQUESTS) begin
				msg = random_message();
				send_message(msg);
				if (msg.message_length >= MIN_LENGTH && (msg.status_byte[7:4] == CMD_NOTE_ON
						|| msg.status_byte[7:4] == CMD_NOTE_OFF
						|| msg.status_byte[7:4] == CMD_CONTROL))
					counted++;
				if (counted == PHASE_REQUESTS / 2 && !paused) begin
					go_idle(0);
					paused = 1'b1;
				end
			end
		end

		go_idle(10);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[midi_sustain_note_tracker] OK");
		end else begin
			$display("[midi_sustain_note_tracker] ERROR");
		end
		$finish;
	end

endmodule

/* midi_sustain_note_tracker.f */
hw/rtl/msnt_pkg.sv
hw/rtl/msnt_tracker.sv
hw/rtl/msnt_result_queue.sv
hw/rtl/midi_sustain_note_tracker.sv
tb/msnt_score_pkg.sv
tb/midi_sustain_note_tracker_test.sv
